// ----- sv/hgss_pkg.sv -----
// shared constants, command and status types for the hibbard-gap shell sorter
package hgss_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int K_W         = $clog2(CNT_W + 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // store the input value, or flag a drop when full
        logic set_k;     // top gap exponent from the element count
        logic pass_init; // i = gap
        logic dec_k;     // next smaller gap
        logic rd_i;      // read store at i
        logic cap_i;     // hold = store[i], j = i
        logic rd_jg;     // read store at j - gap
        logic shift;     // store[j] = store[j - gap], j -= gap
        logic wr_hold;   // store[j] = hold
        logic inc_i;     // i += 1
        logic emit_rd;   // read store at e
        logic emit_ld;   // load the output register
        logic emit_inc;  // e += 1
        logic clear;     // list finished, count and drop flag to zero
    } hgss_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic i_done;    // i >= count
        logic k_one;     // gap exponent is one
        logic j_ge_gap;  // j >= gap
        logic greater;   // store[j - gap] > hold
        logic e_last;    // e is the last element
    } hgss_sts_t;

    // floor(log2(m)) for m >= 1
    function automatic logic [K_W-1:0] floor_log2(input logic [CNT_W:0] m);
        logic [K_W-1:0] r;
        r = '0;
        for (int b = 0; b <= CNT_W; b++) begin
            if (m[b]) begin
                r = K_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/hgss_ram.sv -----
// generic single-write, single-read ram with registered read data
module hgss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/hgss_dp.sv -----
// datapath: element store, sort indexes, compare and output register
module hgss_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hgss_pkg::hgss_cmd_t                cmd,
    output hgss_pkg::hgss_sts_t                sts,
    input  logic [hgss_pkg::VALUE_WIDTH-1:0]   in_value,
    output logic [hgss_pkg::VALUE_WIDTH-1:0]   out_value,
    output logic                               out_last,
    output logic                               out_drop
);

    logic [hgss_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             overflow_reg, overflow_next;
    logic [hgss_pkg::K_W-1:0]         k_reg;
    logic [hgss_pkg::CNT_W-1:0]       i_reg;
    logic [hgss_pkg::ADDR_W-1:0]      j_reg;
    logic [hgss_pkg::ADDR_W-1:0]      e_reg;
    logic [hgss_pkg::VALUE_WIDTH-1:0] hold_reg;
    logic [hgss_pkg::VALUE_WIDTH-1:0] out_value_reg;
    logic                             out_last_reg;
    logic                             out_drop_reg;

    logic                             full;
    logic [hgss_pkg::CNT_W-1:0]       gap_wide;
    logic [hgss_pkg::ADDR_W-1:0]      gap;
    logic [hgss_pkg::ADDR_W-1:0]      j_minus_gap;
    logic                             wr_en;
    logic [hgss_pkg::ADDR_W-1:0]      wr_addr;
    logic [hgss_pkg::VALUE_WIDTH-1:0] wr_data;
    logic [hgss_pkg::ADDR_W-1:0]      rd_addr;
    logic [hgss_pkg::VALUE_WIDTH-1:0] rd_data;

    assign full        = (count_reg == hgss_pkg::CNT_W'(hgss_pkg::DEPTH));
    // gap = 2^k - 1, never above DEPTH - 1
    assign gap_wide    = (hgss_pkg::CNT_W'(1) << k_reg) - hgss_pkg::CNT_W'(1);
    assign gap         = gap_wide[hgss_pkg::ADDR_W-1:0];
    assign j_minus_gap = j_reg - gap;

    // store ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = hold_reg;
        if (cmd.load) begin
            wr_en   = !full;
            wr_addr = count_reg[hgss_pkg::ADDR_W-1:0];
            wr_data = in_value;
        end else if (cmd.shift) begin
            wr_en   = 1'b1;
            wr_data = rd_data;
        end else if (cmd.wr_hold) begin
            wr_en   = 1'b1;
        end
    end

    always_comb begin
        rd_addr = e_reg;
        if (cmd.rd_i) begin
            rd_addr = i_reg[hgss_pkg::ADDR_W-1:0];
        end else if (cmd.rd_jg) begin
            rd_addr = j_minus_gap;
        end
    end

    hgss_ram #(
        .WIDTH(hgss_pkg::VALUE_WIDTH),
        .DEPTH(hgss_pkg::DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // list bookkeeping
    always_comb begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.clear) begin
            count_next    = '0;
            overflow_next = 1'b0;
        end else if (cmd.load) begin
            if (full) begin
                overflow_next = 1'b1;
            end else begin
                count_next = count_reg + hgss_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // sort and emit indexes, hold value, output register
    always_ff @(posedge aclk) begin
        if (cmd.set_k) begin
            k_reg <= hgss_pkg::floor_log2({1'b0, count_reg} + (hgss_pkg::CNT_W + 1)'(1));
            e_reg <= '0;
        end else if (cmd.dec_k) begin
            k_reg <= k_reg - hgss_pkg::K_W'(1);
        end
        if (cmd.pass_init) begin
            i_reg <= gap_wide;
        end else if (cmd.inc_i) begin
            i_reg <= i_reg + hgss_pkg::CNT_W'(1);
        end
        if (cmd.cap_i) begin
            hold_reg <= rd_data;
            j_reg    <= i_reg[hgss_pkg::ADDR_W-1:0];
        end else if (cmd.shift) begin
            j_reg <= j_minus_gap;
        end
        if (cmd.emit_inc) begin
            e_reg <= e_reg + hgss_pkg::ADDR_W'(1);
        end
        if (cmd.emit_ld) begin
            out_value_reg <= rd_data;
            out_last_reg  <= sts.e_last;
            out_drop_reg  <= overflow_reg;
        end
    end

    assign sts.i_done   = (i_reg >= count_reg);
    assign sts.k_one    = (k_reg == hgss_pkg::K_W'(1));
    assign sts.j_ge_gap = (j_reg >= gap);
    assign sts.greater  = ($signed(rd_data) > $signed(hold_reg));
    assign sts.e_last   = (({1'b0, e_reg} + hgss_pkg::CNT_W'(1)) == count_reg);

    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_drop  = out_drop_reg;

endmodule

// ----- sv/hgss_ctrl.sv -----
// controller: load, sort pass and emit sequencing
module hgss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  hgss_pkg::hgss_sts_t sts,
    output hgss_pkg::hgss_cmd_t cmd
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_PASS   = 4'd2;
    localparam logic [3:0] S_TESTI  = 4'd3;
    localparam logic [3:0] S_CAPI   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_EMRD   = 4'd7;
    localparam logic [3:0] S_EMLD   = 4'd8;
    localparam logic [3:0] S_EMWAIT = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                cmd.set_k  = 1'b1;
                state_next = S_PASS;
            end
            S_PASS: begin
                cmd.pass_init = 1'b1;
                state_next    = S_TESTI;
            end
            S_TESTI: begin
                if (sts.i_done) begin
                    if (sts.k_one) begin
                        state_next = S_EMRD;
                    end else begin
                        cmd.dec_k  = 1'b1;
                        state_next = S_PASS;
                    end
                end else begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_CAPI;
                end
            end
            S_CAPI: begin
                cmd.cap_i  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.j_ge_gap) begin
                    cmd.rd_jg  = 1'b1;
                    state_next = S_CMP;
                end else begin
                    cmd.wr_hold = 1'b1;
                    cmd.inc_i   = 1'b1;
                    state_next  = S_TESTI;
                end
            end
            S_CMP: begin
                if (sts.greater) begin
                    cmd.shift  = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    cmd.wr_hold = 1'b1;
                    cmd.inc_i   = 1'b1;
                    state_next  = S_TESTI;
                end
            end
            S_EMRD: begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMLD;
            end
            S_EMLD: begin
                cmd.emit_ld = 1'b1;
                state_next  = S_EMWAIT;
            end
            S_EMWAIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.e_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        cmd.emit_inc = 1'b1;
                        state_next   = S_EMRD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/hibbard_gap_shell_sorter_unit.sv -----
// top level of the hibbard-gap shell sorter
//
// collects signed values, one per input transaction, into a 64-entry store
// until a transaction with tlast; values beyond 64 are discarded and flagged.
// the list is then sorted ascending by shell sort with gaps 2^k-1, k from
// floor(log2(n+1)) down to 1, each pass a gapped insertion sort, and sent out
// one value per output transaction, tlast on the final one and tuser set on
// every one if anything was dropped. s_tready stays high while loading.
// the sort runs on a single-read-port store: each insertion reads the element
// at i, then reads store[j - gap] and shifts it while it exceeds the held value,
// skipping the compare when the element ends at the head of its gap chain.
// each output reads the store, loads its register, waits for tready. input is not
// accepted from the tlast transaction until the last result has been taken.
module hibbard_gap_shell_sorter_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hgss_pkg::TDATA_W-1:0]     s_tdata,   // [31:0] value
    input  logic                             s_tlast,   // last element of the list
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hgss_pkg::TDATA_W-1:0]     m_tdata,   // [31:0] sorted_value
    output logic                             m_tlast,   // final_res
    output logic                             m_tuser    // dropped
);

    hgss_pkg::hgss_cmd_t              cmd;
    hgss_pkg::hgss_sts_t              sts;
    logic [hgss_pkg::VALUE_WIDTH-1:0] out_value;

    // sequencing of load, sort passes and emission
    hgss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tlast (s_tlast),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // store, indexes, compare and output register
    hgss_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_value (s_tdata[hgss_pkg::VALUE_WIDTH-1:0]),
        .out_value(out_value),
        .out_last (m_tlast),
        .out_drop (m_tuser)
    );

    // zero padding up to whole bytes
    assign m_tdata = hgss_pkg::TDATA_W'(out_value);

endmodule

// ----- bench/tb_hibbard_gap_shell_sorter_unit.sv -----
// testbench for the hibbard-gap shell sorter: directed table, then random lists
`timescale 1ns / 100ps

module tb_hibbard_gap_shell_sorter_unit;

    localparam int VALUE_WIDTH = hgss_pkg::VALUE_WIDTH;
    localparam int TDATA_W     = hgss_pkg::TDATA_W;
    localparam int DEPTH       = hgss_pkg::DEPTH;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 336;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 32;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DIR_ROWS       = 22;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // one input transaction, with a typed expectation where it is obvious
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last;
        logic                          typed;
        logic signed [VALUE_WIDTH-1:0] exp_value;
        logic                          exp_final;
        logic                          exp_drop;
    } stim_row_t;

    // one expected output transaction
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   fin;
        logic                   drop;
    } sorted_word_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_THIRD,
        RX_MOSTLY
    } rx_mode_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    // predictor state: the list being collected
    logic signed [VALUE_WIDTH-1:0] held_vals [DEPTH];
    int                            held_cnt   = 0;
    bit                            drop_seen  = 1'b0;
    sorted_word_t                  sorted_expect [$];

    stim_row_t    dir_table [DIR_ROWS];
    sorted_word_t got_word;
    int           error_cnt   = 0;
    int           burst_left  = 0;
    bit           hold_armed  = 1'b0;
    bit           hold_taken  = 1'b0;

    hibbard_gap_shell_sorter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic stim_row_t plain_row(input logic signed [VALUE_WIDTH-1:0] value,
                                            input logic last);
        stim_row_t r;
        r       = '0;
        r.value = value;
        r.last  = last;
        return r;
    endfunction

    // a one-element list comes back unchanged, final set, nothing dropped
    function automatic stim_row_t single_row(input logic signed [VALUE_WIDTH-1:0] value);
        stim_row_t r;
        r           = plain_row(value, 1'b1);
        r.typed     = 1'b1;
        r.exp_value = value;
        r.exp_final = 1'b1;
        r.exp_drop  = 1'b0;
        return r;
    endfunction

    // mix of full-range values, small values for duplicates, and the extremes
    function automatic logic signed [VALUE_WIDTH-1:0] draw_value();
        int                            pick;
        int                            near;
        logic signed [VALUE_WIDTH-1:0] v;
        pick = $urandom_range(0, 9);
        near = $urandom_range(0, 3);
        if (pick <= 5) begin
            v = VALUE_WIDTH'({$urandom(), $urandom()});
        end else if (pick <= 7) begin
            v = VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
        end else if (pick == 8) begin
            case (near)
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = '0;
                default: v = '1;
            endcase
        end else begin
            v = ($urandom_range(0, 1) == 0) ? VAL_MAX - VALUE_WIDTH'(near)
                                            : VAL_MIN + VALUE_WIDTH'(near);
        end
        return v;
    endfunction

    // collect one accepted element; on the last one sort with hibbard gaps
    // and queue one expected transaction per held element
    task automatic collect_and_sort(input stim_row_t row);
        int                            k;
        int                            gap;
        int                            j;
        logic signed [VALUE_WIDTH-1:0] hold;
        sorted_word_t                  w;
        if (held_cnt < DEPTH) begin
            held_vals[held_cnt] = row.value;
            held_cnt++;
        end else begin
            drop_seen = 1'b1;
        end
        if (row.last) begin
            k = 0;
            while ((1 << (k + 1)) <= held_cnt + 1) k++;
            for (; k > 0; k--) begin
                gap = (1 << k) - 1;
                for (int i = gap; i < held_cnt; i++) begin
                    hold = held_vals[i];
                    j    = i;
                    while (j >= gap && held_vals[j - gap] > hold) begin
                        held_vals[j] = held_vals[j - gap];
                        j -= gap;
                    end
                    held_vals[j] = hold;
                end
            end
            if (row.typed) begin
                w.value = row.exp_value;
                w.fin   = row.exp_final;
                w.drop  = row.exp_drop;
                sorted_expect = {sorted_expect, w};
            end else begin
                for (int e = 0; e < held_cnt; e++) begin
                    w.value = held_vals[e];
                    w.fin   = (e == held_cnt - 1);
                    w.drop  = drop_seen;
                    sorted_expect = {sorted_expect, w};
                end
            end
            held_cnt  = 0;
            drop_seen = 1'b0;
        end
    endtask

    // offer one transaction right after a rising edge, wait for the handshake,
    // then pause between bursts; s_tready is sampled at the falling edge
    task automatic offer_item(input stim_row_t row);
        logic [TDATA_W-1:0] word;
        bit                 taken;
        int                 gap;
        word                   = '0;
        word[VALUE_WIDTH-1:0]  = row.value;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= row.last;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        collect_and_sort(row);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver: segments of different stall patterns, plus one long hold-off
    // once the random part runs and a result is waiting
    initial begin
        rx_mode_t rx_mode;
        int       seg_left;
        int       phase;
        logic     rdy;
        rx_mode  = RX_ALWAYS;
        seg_left = 0;
        phase    = 0;
        forever begin
            @(posedge aclk);
            if (hold_armed && !hold_taken && m_tvalid) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 80);
                    phase    = 0;
                end
                seg_left--;
                phase++;
                case (rx_mode)
                    RX_ALWAYS:      rdy = 1'b1;
                    RX_COIN:        rdy = 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: rdy = (phase % 3 == 0);
                    default:        rdy = ($urandom_range(0, 3) != 0);
                endcase
                m_tready <= rdy;
            end
        end
    end

    // result checker: a transaction seen at the falling edge completes at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_expect.size() == 0) begin
                $display("%0t: unexpected result, actual value %h last %b user %b",
                         $time, m_tdata[VALUE_WIDTH-1:0], m_tlast, m_tuser);
                error_cnt++;
            end else begin
                got_word = sorted_expect.pop_front();
                if (m_tdata[VALUE_WIDTH-1:0] !== got_word.value) begin
                    $display("%0t: sorted_value mismatch, expected %h, actual %h",
                             $time, got_word.value, m_tdata[VALUE_WIDTH-1:0]);
                    error_cnt++;
                end
                if (m_tlast !== got_word.fin) begin
                    $display("%0t: final_res mismatch, expected %b, actual %b",
                             $time, got_word.fin, m_tlast);
                    error_cnt++;
                end
                if (m_tuser !== got_word.drop) begin
                    $display("%0t: dropped mismatch, expected %b, actual %b",
                             $time, got_word.drop, m_tuser);
                    error_cnt++;
                end
            end
        end
    end

    initial begin
        int        sent;
        int        len;
        int        big_lists;
        stim_row_t row;

        // one-element lists straight after reset: the extremes, zero, minus one and one
        dir_table[0] = single_row(VAL_MAX);
        dir_table[1] = single_row(VAL_MIN);
        dir_table[2] = single_row('0);
        dir_table[3] = single_row('1);
        dir_table[4] = single_row(1);
        // extremes mixed in one list, with a repeated minimum
        dir_table[5]  = plain_row(VAL_MAX, 1'b0);
        dir_table[6]  = plain_row(VAL_MIN, 1'b0);
        dir_table[7]  = plain_row('0, 1'b0);
        dir_table[8]  = plain_row('1, 1'b0);
        dir_table[9]  = plain_row(1, 1'b0);
        dir_table[10] = plain_row(VAL_MIN, 1'b1);
        // descending list of eight, gaps 7, 3, 1
        for (int v = 7; v >= 0; v--) dir_table[18 - v] = plain_row(v, v == 0);
        // all equal
        dir_table[19] = plain_row(5, 1'b0);
        dir_table[20] = plain_row(5, 1'b0);
        dir_table[21] = plain_row(5, 1'b1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) offer_item(dir_table[r]);

        // random part: a full store, then overflowing lists where the last element
        // itself is dropped, then mostly short lists
        hold_armed = 1'b1;
        sent       = 0;
        big_lists  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (big_lists == 0) begin
                len = DEPTH;
            end else if (big_lists == 1) begin
                len = DEPTH + 1;
            end else if (big_lists == 2) begin
                len = DEPTH + $urandom_range(2, 6);
            end else if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(1, 12);
            end
            if (big_lists < 3) big_lists++;
            for (int e = 0; e < len; e++) begin
                row       = '0;
                row.value = draw_value();
                row.last  = (e == len - 1);
                offer_item(row);
            end
            sent += len;
        end
        s_tvalid <= 1'b0;

        while (sorted_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

endmodule
